[rtl/ctf_pkg.sv]
// ----------------------------------------------------------------------------
// ctf_pkg
// Shared types, constants and fixed-point helpers of the complementary tilt
// filter.
// ----------------------------------------------------------------------------
`default_nettype none

package ctf_pkg;

  localparam int NUM_AXES_DEF     = 3;
  localparam int CORDIC_STEPS_DEF = 16;

  // 16.16 constants, held at multiplier operand width
  localparam logic signed [32:0] FIX_ONE    = 33'sd65536;
  localparam logic signed [32:0] RAD_TO_DEG = 33'sd3754936;
  localparam logic signed [32:0] ACC_GAIN   = 33'sd4390912;  // 67.0 in 16.16
  localparam logic signed [32:0] MS_RECIP   = 33'sd4294968;  // ceil(2^32 / 1000)
  localparam logic signed [32:0] MS_PER_S   = 33'sd1000;
  localparam logic [30:0]        MS_HALF    = 31'd500;
  localparam logic signed [31:0] FIX_PI     = 32'sd205887;

  localparam logic [1:0] AXIS_GYRO_ONLY = 2'd2;
  localparam logic [1:0] AXIS_NONE      = 2'd3;

  typedef logic signed [50:0] wide_t;

  typedef enum logic [2:0] {
    CFG_BLEND  = 3'd0,
    CFG_SMOOTH = 3'd1,
    CFG_DB0    = 3'd2,
    CFG_DB1    = 3'd3,
    CFG_DB2    = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [16:0]      blend;
    logic [16:0]      smooth;
    logic [2:0][14:0] deadband;
  } cfg_t;

  typedef struct packed {
    logic [1:0]         axis;
    logic               axis_ok;
    logic signed [15:0] gyro_rate;
    logic signed [15:0] accel_y_part;
    logic signed [15:0] accel_x_part;
    logic [30:0]        ms_num;      // elapsed_ms * 65536 + 500
  } item_t;

  function automatic logic [16:0] atan_lut(input logic [4:0] i);
    logic [16:0] v;
    unique case (i)
      5'd0:    v = 17'd51472;
      5'd1:    v = 17'd30385;
      5'd2:    v = 17'd16055;
      5'd3:    v = 17'd8150;
      5'd4:    v = 17'd4091;
      5'd5:    v = 17'd2047;
      5'd6:    v = 17'd1024;
      5'd7:    v = 17'd512;
      5'd8:    v = 17'd256;
      5'd9:    v = 17'd128;
      5'd10:   v = 17'd64;
      5'd11:   v = 17'd32;
      5'd12:   v = 17'd16;
      5'd13:   v = 17'd8;
      5'd14:   v = 17'd4;
      5'd15:   v = 17'd2;
      5'd16:   v = 17'd1;
      default: v = 17'd0;
    endcase
    return v;
  endfunction

  function automatic logic signed [31:0] sat32(input wide_t v);
    logic signed [31:0] r;
    if (v > 51'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -51'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // 32.32 product to 16.16: floor shift, add bit 15, saturate
  function automatic logic signed [31:0] fround(input logic signed [65:0] p);
    wide_t r;
    r = wide_t'(p >>> 16) + wide_t'({1'b0, p[15]});
    return sat32(r);
  endfunction

endpackage

`default_nettype wire

[rtl/ctf_if.sv]
// ----------------------------------------------------------------------------
// ctf_if
// Channel interfaces: sample items, angle results and register writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface ctf_item_if;
  logic               valid;
  logic               ready;
  logic [1:0]         axis;
  logic signed [15:0] gyro_rate;
  logic signed [15:0] accel_y_part;
  logic signed [15:0] accel_x_part;
  logic [14:0]        elapsed_ms;

  modport source (output valid, axis, gyro_rate, accel_y_part, accel_x_part, elapsed_ms,
                  input ready);
  modport sink (input valid, axis, gyro_rate, accel_y_part, accel_x_part, elapsed_ms,
                output ready);
endinterface

interface ctf_result_if;
  logic               valid;
  logic               ready;
  logic [1:0]         axis_out;
  logic signed [31:0] angle;

  modport source (output valid, axis_out, angle, input ready);
  modport sink (input valid, axis_out, angle, output ready);
endinterface

interface ctf_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [16:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

[rtl/ctf_front.sv]
// ----------------------------------------------------------------------------
// ctf_front
// Accepts sample transactions and register writes, classifies the axis,
// precomputes the time-step numerator and queues items for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module ctf_front #(
  parameter int NUM_AXES = ctf_pkg::NUM_AXES_DEF
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  ctf_item_if.sink            item_i,
  ctf_cfg_if.sink             cfg_i,
  output ctf_pkg::item_t      head_o,
  output logic                head_valid_o,
  input  wire logic           head_pop_i,
  output ctf_pkg::cfg_t       cfg_o
);
  import ctf_pkg::*;

  item_t      entry_q [2];
  item_t      new_item;
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;
  logic       push, pop;
  cfg_t       cfg_q;

  always_comb begin
    new_item.axis         = item_i.axis;
    new_item.axis_ok      = (32'(item_i.axis) < 32'(NUM_AXES)) && (item_i.axis != AXIS_NONE);
    new_item.gyro_rate    = item_i.gyro_rate;
    new_item.accel_y_part = item_i.accel_y_part;
    new_item.accel_x_part = item_i.accel_x_part;
    new_item.ms_num       = 31'({item_i.elapsed_ms, 16'h0000}) + MS_HALF;
  end

  assign item_i.ready = (count_q != 2'd2);
  assign push         = item_i.valid && item_i.ready;
  assign head_valid_o = (count_q != 2'd0);
  assign pop          = head_pop_i && head_valid_o;
  assign head_o       = entry_q[rd_ptr_q];
  assign cfg_i.ready  = 1'b1;
  assign cfg_o        = cfg_q;

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= new_item;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q        <= 1'b0;
      rd_ptr_q        <= 1'b0;
      count_q         <= 2'd0;
      cfg_q.blend     <= 17'd64225;
      cfg_q.smooth    <= 17'd64881;
      cfg_q.deadband  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      count_q <= count_q + 2'(push) - 2'(pop);
      if (cfg_i.valid) begin
        unique case (cfg_idx_e'(cfg_i.index))
          CFG_BLEND:  cfg_q.blend       <= cfg_i.data;
          CFG_SMOOTH: cfg_q.smooth      <= cfg_i.data;
          CFG_DB0:    cfg_q.deadband[0] <= cfg_i.data[14:0];
          CFG_DB1:    cfg_q.deadband[1] <= cfg_i.data[14:0];
          CFG_DB2:    cfg_q.deadband[2] <= cfg_i.data[14:0];
          default: ;
        endcase
      end
    end
  end

endmodule

`default_nettype wire

[rtl/ctf_back.sv]
// ----------------------------------------------------------------------------
// ctf_back
// Executes one queued item: bias correction, iterative CORDIC atan2 and a
// sequence of products on one shared multiplier, then the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ctf_back #(
  parameter int NUM_AXES     = ctf_pkg::NUM_AXES_DEF,
  parameter int CORDIC_STEPS = ctf_pkg::CORDIC_STEPS_DEF
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire ctf_pkg::item_t head_i,
  input  wire logic           head_valid_i,
  output logic                head_pop_o,
  input  wire ctf_pkg::cfg_t  cfg_i,
  ctf_result_if.source        result_o
);
  import ctf_pkg::*;

  localparam int AXW = (NUM_AXES > 1) ? $clog2(NUM_AXES) : 1;
  localparam int IW  = $clog2(CORDIC_STEPS);
  localparam logic [IW-1:0] LAST_ITER = IW'(CORDIC_STEPS - 1);

  typedef enum logic [2:0] {S_IDLE, S_CORD, S_MUL, S_RES, S_DONE} state_e;
  typedef enum logic [3:0] {
    OP_BIAS0, OP_BIAS1, OP_DEG, OP_SCALE, OP_DT0, OP_DT1, OP_INT, OP_BL0, OP_BL1
  } op_e;

  state_e             state_q;
  op_e                op_q;
  logic [IW-1:0]      iter_q;
  logic [1:0]         axis_q;
  logic [AXW-1:0]     idx_q;
  logic               band_q;
  logic signed [31:0] gyro_q, filt_q, z_q, acc_q, t1_q, dt_q, inner_q, new_q;
  logic [30:0]        num_q;
  logic signed [33:0] x_q, y_q;
  logic signed [65:0] prod_q;
  logic signed [31:0] bias_q  [NUM_AXES];
  logic signed [31:0] angle_q [NUM_AXES];
  logic               res_valid_q;
  logic [1:0]         res_axis_q;
  logic signed [31:0] res_angle_q;

  logic [AXW-1:0]     idx_w;
  logic signed [31:0] gyro_w, filt_w, abs_w, fr;
  logic [14:0]        db_w;
  logic               band_w;
  logic signed [33:0] x0, y0, xs, ys;
  logic signed [31:0] z0;
  logic [16:0]        atan_w;
  logic signed [32:0] k_w, mul_a, mul_b;
  logic               res_load;

  always_comb begin
    idx_w  = AXW'(head_i.axis);
    gyro_w = {head_i.gyro_rate, 16'h0000};
    filt_w = sat32(wide_t'(gyro_w) - wide_t'(bias_q[idx_w]));
    abs_w  = filt_w[31] ? sat32(-wide_t'(filt_w)) : filt_w;
    unique case (head_i.axis)
      2'd0:    db_w = cfg_i.deadband[0];
      2'd1:    db_w = cfg_i.deadband[1];
      2'd2:    db_w = cfg_i.deadband[2];
      default: db_w = 15'd0;
    endcase
    band_w = wide_t'(abs_w) < wide_t'({1'b0, db_w, 16'h0000});

    // prerotate into the right half plane
    x0 = {{4{head_i.accel_x_part[15]}}, head_i.accel_x_part, 14'h0000};
    y0 = {{4{head_i.accel_y_part[15]}}, head_i.accel_y_part, 14'h0000};
    z0 = 32'sd0;
    if (x0 < 0) begin
      z0 = head_i.accel_y_part[15] ? -FIX_PI : FIX_PI;
      x0 = -x0;
      y0 = -y0;
    end

    xs     = x_q >>> iter_q;
    ys     = y_q >>> iter_q;
    atan_w = atan_lut(5'(iter_q));

    k_w = (axis_q == AXIS_GYRO_ONLY) ? FIX_ONE : 33'({16'h0000, cfg_i.blend});
    unique case (op_q)
      OP_BIAS0: begin mul_a = 33'(bias_q[idx_q]); mul_b = 33'({16'h0000, cfg_i.smooth}); end
      OP_BIAS1: begin mul_a = 33'(gyro_q); mul_b = FIX_ONE - 33'({16'h0000, cfg_i.smooth}); end
      OP_DEG:   begin mul_a = 33'(z_q);    mul_b = RAD_TO_DEG; end
      OP_SCALE: begin mul_a = 33'(acc_q);  mul_b = ACC_GAIN; end
      OP_DT0:   begin mul_a = 33'({2'b00, num_q}); mul_b = MS_RECIP; end
      OP_DT1:   begin mul_a = 33'(dt_q);   mul_b = MS_PER_S; end
      OP_INT:   begin mul_a = 33'(filt_q); mul_b = 33'(dt_q); end
      OP_BL0:   begin mul_a = k_w;         mul_b = 33'(inner_q); end
      OP_BL1:   begin mul_a = FIX_ONE - k_w; mul_b = 33'(acc_q); end
      default:  begin mul_a = '0;          mul_b = '0; end
    endcase
    fr = fround(prod_q);
  end

  assign head_pop_o      = (state_q == S_IDLE) && head_valid_i;
  assign res_load        = (state_q == S_DONE) && (!res_valid_q || result_o.ready);
  assign result_o.valid    = res_valid_q;
  assign result_o.axis_out = res_axis_q;
  assign result_o.angle    = res_angle_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      op_q        <= OP_BIAS0;
      iter_q      <= '0;
      axis_q      <= '0;
      idx_q       <= '0;
      band_q      <= 1'b0;
      gyro_q      <= '0;
      filt_q      <= '0;
      z_q         <= '0;
      acc_q       <= '0;
      t1_q        <= '0;
      dt_q        <= '0;
      inner_q     <= '0;
      new_q       <= '0;
      num_q       <= '0;
      x_q         <= '0;
      y_q         <= '0;
      prod_q      <= '0;
      res_valid_q <= 1'b0;
      res_axis_q  <= '0;
      res_angle_q <= '0;
      for (int i = 0; i < NUM_AXES; i++) begin
        bias_q[i]  <= '0;
        angle_q[i] <= '0;
      end
    end else begin
      if (res_load) begin
        res_valid_q <= 1'b1;
      end else if (result_o.valid && result_o.ready) begin
        res_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (head_valid_i) begin
            axis_q <= head_i.axis;
            idx_q  <= idx_w;
            gyro_q <= gyro_w;
            filt_q <= filt_w;
            band_q <= band_w;
            num_q  <= head_i.ms_num;
            x_q    <= x0;
            y_q    <= y0;
            z_q    <= z0;
            new_q  <= '0;
            iter_q <= '0;
            op_q   <= OP_BIAS0;
            state_q <= head_i.axis_ok ? S_CORD : S_DONE;
          end
        end
        S_CORD: begin
          if (y_q > 0) begin
            x_q <= x_q + ys;
            y_q <= y_q - xs;
            z_q <= z_q + 32'(atan_w);
          end else if (y_q < 0) begin
            x_q <= x_q - ys;
            y_q <= y_q + xs;
            z_q <= z_q - 32'(atan_w);
          end
          iter_q <= iter_q + 1'b1;
          if (iter_q == LAST_ITER) begin
            state_q <= S_MUL;
          end
        end
        S_MUL: begin
          prod_q  <= 66'(mul_a) * 66'(mul_b);
          state_q <= S_RES;
        end
        S_RES: begin
          state_q <= S_MUL;
          op_q    <= op_e'(op_q + 4'd1);
          unique case (op_q)
            OP_BIAS0: t1_q <= fr;
            OP_BIAS1: begin
              if (band_q) begin
                bias_q[idx_q] <= sat32(wide_t'(t1_q) + wide_t'(fr));
              end
            end
            OP_DEG:   acc_q <= fr;
            OP_SCALE: acc_q <= fr;
            OP_DT0:   dt_q  <= signed'(prod_q[63:32]);
            OP_DT1: begin
              // reciprocal estimate is at most one too high
              if (prod_q > signed'({35'h0, num_q})) begin
                dt_q <= dt_q - 32'sd1;
              end
            end
            OP_INT:   inner_q <= sat32(wide_t'(angle_q[idx_q]) + wide_t'(fr));
            OP_BL0:   t1_q <= fr;
            OP_BL1: begin
              new_q          <= sat32(wide_t'(t1_q) + wide_t'(fr));
              angle_q[idx_q] <= sat32(wide_t'(t1_q) + wide_t'(fr));
              state_q        <= S_DONE;
            end
            default: ;
          endcase
        end
        S_DONE: begin
          if (res_load) begin
            res_axis_q  <= axis_q;
            res_angle_q <= new_q;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

[rtl/complementary_tilt_filter.sv]
// ----------------------------------------------------------------------------
// complementary_tilt_filter
// Per-axis complementary tilt filter with gyro bias tracking, 16.16 math.
// ----------------------------------------------------------------------------
// Usage:
//   item_i carries one sample transaction: axis, raw gyro rate, two
//   accelerometer components and elapsed milliseconds. result_o returns one
//   transaction per sample: the axis and its new angle (signed 16.16).
//   cfg_i writes the blend weight, bias smoothing weight and three deadbands
//   by register index; it is always ready. The user must write it only
//   while idle; the block does not enforce this. A two-entry queue decouples
//   intake from execution, so item_i stays ready while one item runs and
//   one waits. Per valid-axis item the back end loads it, runs CORDIC_STEPS
//   CORDIC iterations and nine products on the shared multiplier (an issue
//   and a write-back step each), then hands over; it takes no new item
//   before the hand-over. Items with an unused axis go straight from load
//   to hand-over and return angle zero. Reset clears bias and angle state,
//   the queue and the output register and restores register defaults. A
//   stalled receiver holds the result; the back end then waits in its
//   hand-over step and the queue fills.
// ----------------------------------------------------------------------------
`default_nettype none

module complementary_tilt_filter #(
  parameter int NUM_AXES     = ctf_pkg::NUM_AXES_DEF,
  parameter int CORDIC_STEPS = ctf_pkg::CORDIC_STEPS_DEF
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  ctf_item_if.sink     item_i,
  ctf_cfg_if.sink      cfg_i,
  ctf_result_if.source result_o
);
  import ctf_pkg::*;

  item_t head;
  logic  head_valid, head_pop;
  cfg_t  cfg;

  ctf_front #(
    .NUM_AXES (NUM_AXES)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_i       (item_i),
    .cfg_i        (cfg_i),
    .head_o       (head),
    .head_valid_o (head_valid),
    .head_pop_i   (head_pop),
    .cfg_o        (cfg)
  );

  ctf_back #(
    .NUM_AXES     (NUM_AXES),
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head),
    .head_valid_i (head_valid),
    .head_pop_o   (head_pop),
    .cfg_i        (cfg),
    .result_o     (result_o)
  );

endmodule

`default_nettype wire

[rtl/ctf_checker.sv]
// ----------------------------------------------------------------------------
// ctf_checker
// Port-level checks of the complementary tilt filter, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ctf_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_ready,
  input wire logic        cfg_ready,
  input wire logic        res_valid,
  input wire logic        res_ready,
  input wire logic [1:0]  res_axis,
  input wire logic [31:0] res_angle
);
  import ctf_pkg::*;

  // stalled result holds its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && !res_ready |=> $stable(res_angle) && $stable(res_axis))
    else $error("result changed while stalled");

  // unused axis code reports a zero angle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && (res_axis == AXIS_NONE) |-> (res_angle == 32'h0))
    else $error("unused axis returned nonzero angle");

  // intake is ready and no result is valid right after reset
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(!rst_ni) |-> in_ready && !res_valid)
    else $error("not empty after reset");

  assert property (@(posedge clk_i) disable iff (!rst_ni) cfg_ready)
    else $error("register write port stalled");

endmodule

bind complementary_tilt_filter ctf_checker u_ctf_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .in_ready  (item_i.ready),
  .cfg_ready (cfg_i.ready),
  .res_valid (result_o.valid),
  .res_ready (result_o.ready),
  .res_axis  (result_o.axis_out),
  .res_angle (result_o.angle)
);

`default_nettype wire
